[hw/rtl/opi_pkg.sv]
// package for the odometry pose integrator: item structs, cordic constants
// no dependencies
package opi_pkg;

    localparam int CORDIC_STEPS = 16;
    localparam int CORDIC_START = 19899;
    localparam int Q15_MAX      = 32767;

    typedef struct packed {
        logic               kind;
        logic signed [23:0] meas_x;
        logic signed [23:0] meas_z;
        logic        [15:0] meas_yaw;
        logic signed [39:0] load_x;
        logic signed [39:0] load_z;
        logic        [15:0] load_heading;
    } opi_in_t;

    typedef struct packed {
        logic signed [39:0] pose_x;
        logic signed [39:0] pose_z;
        logic        [15:0] pose_heading;
    } opi_out_t;

    function automatic logic [15:0] atan_lut(input logic [3:0] i);
        logic [15:0] r;
        begin
            case (i)
                4'd0:  r = 16'd8192;
                4'd1:  r = 16'd4836;
                4'd2:  r = 16'd2555;
                4'd3:  r = 16'd1297;
                4'd4:  r = 16'd651;
                4'd5:  r = 16'd326;
                4'd6:  r = 16'd163;
                4'd7:  r = 16'd81;
                4'd8:  r = 16'd41;
                4'd9:  r = 16'd20;
                4'd10: r = 16'd10;
                4'd11: r = 16'd5;
                4'd12: r = 16'd3;
                4'd13: r = 16'd1;
                4'd14: r = 16'd1;
                default: r = 16'd0;
            endcase
            return r;
        end
    endfunction

endpackage

[hw/rtl/odometry_pose_integrator_top.sv]
// top level of the odometry pose integrator: sequencer and pose state
// depends on opi_pkg, opi_cordic, opi_mac
//
// An update item runs two CORDIC passes, for the heading and the previous
// yaw, then eight products through one bit-serial multiplier, then the
// rounding and saturating add, then the output register, and goes back to
// idle. A set item loads the pose and goes straight to the output register.
// One item is in work at a time; the result sits in an output register and
// the next item is taken in the cycle after it has gone.
module odometry_pose_integrator_top
    import opi_pkg::*;
#(
    parameter int ANGLE_BITS = 16
) (
    input  logic     aclk,
    input  logic     aresetn,
    input  logic     s_valid,
    output logic     s_ready,
    input  opi_in_t  s_data,
    input  logic     m_ready,
    output logic     m_valid,
    output opi_out_t m_data
);

    typedef enum logic [2:0] {
        ST_IDLE, ST_COR0, ST_COR1, ST_MUL, ST_FIN, ST_OUT
    } state_t;

    state_t             state_reg;
    logic signed [23:0] prev_x_reg, prev_z_reg;
    logic [15:0]        prev_yaw_reg, acc_h_reg;
    logic signed [39:0] acc_x_reg, acc_z_reg;
    logic signed [24:0] dx_reg, dz_reg;
    logic signed [15:0] s0_reg, c0_reg, s1_reg, c1_reg;
    logic signed [41:0] ix_reg, iz_reg;
    logic signed [57:0] nx_reg, nz_reg;
    logic [2:0]         mi_reg;
    logic               mstart_reg, cstart_reg;
    logic [15:0]        cang_reg;

    logic               c_done, m_done;
    logic signed [15:0] c_sin, c_cos;
    logic signed [41:0] m_a;
    logic signed [15:0] m_b;
    logic signed [57:0] m_p;
    logic signed [57:0] rx, rz;
    logic signed [41:0] sx, sz;

    opi_cordic #(.ANGLE_BITS(ANGLE_BITS)) u_cordic (
        .aclk(aclk), .aresetn(aresetn), .start(cstart_reg), .angle(cang_reg),
        .done(c_done), .sin_q(c_sin), .cos_q(c_cos)
    );

    opi_mac #(.AW(42)) u_mac (
        .aclk(aclk), .aresetn(aresetn), .start(mstart_reg), .a(m_a), .b(m_b),
        .done(m_done), .p(m_p)
    );

    // product schedule: 0..3 build ix/iz, 4..7 build nx/nz
    always_comb begin
        case (mi_reg)
            3'd0: begin m_a = 42'(dx_reg); m_b = c0_reg; end
            3'd1: begin m_a = 42'(dz_reg); m_b = s0_reg; end
            3'd2: begin m_a = 42'(dx_reg); m_b = s0_reg; end
            3'd3: begin m_a = 42'(dz_reg); m_b = c0_reg; end
            3'd4: begin m_a = ix_reg;      m_b = c1_reg; end
            3'd5: begin m_a = iz_reg;      m_b = s1_reg; end
            3'd6: begin m_a = iz_reg;      m_b = c1_reg; end
            default: begin m_a = ix_reg;   m_b = s1_reg; end
        endcase
        rx = (nx_reg + 58'sd2097152) >>> 22;
        rz = (nz_reg + 58'sd2097152) >>> 22;
        sx = 42'(acc_x_reg) + 42'(rx);
        sz = 42'(acc_z_reg) + 42'(rz);
    end

    function automatic logic signed [39:0] sat40(input logic signed [41:0] v);
        if (v > 42'sh0_7F_FFFF_FFFF)       return 40'sh7F_FFFF_FFFF;
        else if (v < -42'sh0_80_0000_0000) return 40'sh80_0000_0000;
        else                               return v[39:0];
    endfunction

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= ST_IDLE;
            prev_x_reg   <= '0;
            prev_z_reg   <= '0;
            prev_yaw_reg <= '0;
            acc_x_reg    <= '0;
            acc_z_reg    <= '0;
            acc_h_reg    <= '0;
            mstart_reg   <= 1'b0;
            cstart_reg   <= 1'b0;
            mi_reg       <= '0;
        end else begin
            mstart_reg <= 1'b0;
            cstart_reg <= 1'b0;
            unique case (state_reg)
                ST_IDLE: begin
                    if (s_valid) begin
                        prev_x_reg   <= s_data.meas_x;
                        prev_z_reg   <= s_data.meas_z;
                        prev_yaw_reg <= s_data.meas_yaw;
                        if (s_data.kind) begin
                            acc_x_reg <= s_data.load_x;
                            acc_z_reg <= s_data.load_z;
                            acc_h_reg <= s_data.load_heading;
                            state_reg <= ST_OUT;
                        end else begin
                            dx_reg     <= 25'(s_data.meas_x) - 25'(prev_x_reg);
                            dz_reg     <= 25'(s_data.meas_z) - 25'(prev_z_reg);
                            // heading advance computed now, old heading kept for cordic
                            acc_h_reg  <= acc_h_reg + s_data.meas_yaw - prev_yaw_reg;
                            cang_reg   <= acc_h_reg;
                            cstart_reg <= 1'b1;
                            state_reg  <= ST_COR1;
                        end
                    end
                end
                ST_COR1: begin
                    if (c_done) begin
                        s1_reg     <= c_sin;
                        c1_reg     <= c_cos;
                        cang_reg   <= prev_yaw_reg - (acc_h_reg - cang_reg) ;
                        cstart_reg <= 1'b1;
                        state_reg  <= ST_COR0;
                    end
                end
                ST_COR0: begin
                    if (c_done) begin
                        s0_reg     <= c_sin;
                        c0_reg     <= c_cos;
                        mi_reg     <= '0;
                        mstart_reg <= 1'b1;
                        state_reg  <= ST_MUL;
                    end
                end
                ST_MUL: begin
                    if (m_done) begin
                        case (mi_reg)
                            3'd0: ix_reg <= 42'(m_p);
                            3'd1: ix_reg <= ix_reg - 42'(m_p);
                            3'd2: iz_reg <= 42'(m_p);
                            3'd3: iz_reg <= iz_reg + 42'(m_p);
                            3'd4: nx_reg <= m_p;
                            3'd5: nx_reg <= nx_reg + m_p;
                            3'd6: nz_reg <= m_p;
                            default: nz_reg <= nz_reg - m_p;
                        endcase
                        mi_reg <= mi_reg + 3'd1;
                        if (mi_reg == 3'd7) state_reg <= ST_FIN;
                        else mstart_reg <= 1'b1;
                    end
                end
                ST_FIN: begin
                    acc_x_reg <= sat40(sx);
                    acc_z_reg <= sat40(sz);
                    state_reg <= ST_OUT;
                end
                ST_OUT: begin
                    if (m_ready) state_reg <= ST_IDLE;
                end
                default: state_reg <= ST_IDLE;
            endcase
        end
    end

    assign s_ready             = (state_reg == ST_IDLE);
    assign m_valid             = (state_reg == ST_OUT);
    assign m_data.pose_x       = acc_x_reg;
    assign m_data.pose_z       = acc_z_reg;
    assign m_data.pose_heading = acc_h_reg;

endmodule

[hw/rtl/opi_cordic.sv]
// iterative rotation-mode cordic: one micro-rotation per cycle, q1.15 sin/cos
// depends on opi_pkg
module opi_cordic
    import opi_pkg::*;
#(
    parameter int ANGLE_BITS = 16
) (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               start,
    input  logic [15:0]        angle,
    output logic               done,
    output logic signed [15:0] sin_q,
    output logic signed [15:0] cos_q
);

    // low angle bits dropped only when the angle is narrower than 16 bits
    localparam int ANGLE_DROP = (ANGLE_BITS < 16) ? 16 - ANGLE_BITS : 0;

    logic signed [19:0] x_reg, y_reg;
    logic signed [17:0] z_reg;
    logic               neg_reg;
    logic               busy_reg;
    logic [3:0]         step_reg;
    logic               done_reg;
    logic signed [15:0] sin_reg, cos_reg;

    logic [15:0]        a_m;
    logic signed [19:0] xs, ys, x_next, y_next, xf, yf;
    logic signed [17:0] z_next;

    function automatic logic signed [15:0] clamp(input logic signed [19:0] v);
        if (v > 20'sd32767)       return 16'sd32767;
        else if (v < -20'sd32767) return -16'sd32767;
        else                      return v[15:0];
    endfunction

    always_comb begin
        a_m = angle & ~((16'd1 << ANGLE_DROP) - 16'd1);
        xs = x_reg >>> step_reg;
        ys = y_reg >>> step_reg;
        if (!z_reg[17]) begin
            x_next = x_reg - ys;
            y_next = y_reg + xs;
            z_next = z_reg - 18'(atan_lut(step_reg));
        end else begin
            x_next = x_reg + ys;
            y_next = y_reg - xs;
            z_next = z_reg + 18'(atan_lut(step_reg));
        end
        xf = neg_reg ? -x_next : x_next;
        yf = neg_reg ? -y_next : y_next;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            step_reg <= '0;
        end else begin
            done_reg <= 1'b0;
            if (start) begin
                busy_reg <= 1'b1;
                step_reg <= '0;
                x_reg    <= 20'(CORDIC_START);
                y_reg    <= '0;
                // fold into the right half plane
                if (a_m >= 16'd16384 && a_m < 16'd49152) begin
                    z_reg   <= 18'($signed({2'b00, a_m})) - 18'sd32768;
                    neg_reg <= 1'b1;
                end else if (a_m >= 16'd49152) begin
                    z_reg   <= 18'($signed({2'b00, a_m})) - 18'sd65536;
                    neg_reg <= 1'b0;
                end else begin
                    z_reg   <= 18'($signed({2'b00, a_m}));
                    neg_reg <= 1'b0;
                end
            end else if (busy_reg) begin
                x_reg    <= x_next;
                y_reg    <= y_next;
                z_reg    <= z_next;
                step_reg <= step_reg + 4'd1;
                if (step_reg == 4'(CORDIC_STEPS - 1)) begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                    cos_reg  <= clamp(xf);
                    sin_reg  <= clamp(yf);
                end
            end
        end
    end

    assign done  = done_reg;
    assign sin_q = sin_reg;
    assign cos_q = cos_reg;

endmodule

[hw/rtl/opi_mac.sv]
// digit-serial multiplier: signed operand a times signed 16-bit b,
// one bit of b a cycle, shift-add; no package dependency
module opi_mac #(
    parameter int AW = 42
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  start,
    input  logic signed [AW-1:0]  a,
    input  logic signed [15:0]    b,
    output logic                  done,
    output logic signed [AW+15:0] p
);

    logic signed [AW+15:0] acc_reg;
    logic signed [AW+15:0] a_reg;
    logic [15:0]           b_reg;
    logic [3:0]            cnt_reg;
    logic                  busy_reg, done_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            done_reg <= 1'b0;
            if (start) begin
                busy_reg <= 1'b1;
                cnt_reg  <= '0;
                acc_reg  <= '0;
                a_reg    <= (AW+16)'(a);
                b_reg    <= b;
            end else if (busy_reg) begin
                // msb of b carries negative weight
                if (b_reg[0])
                    acc_reg <= (cnt_reg == 4'd15) ? acc_reg - a_reg : acc_reg + a_reg;
                a_reg   <= a_reg <<< 1;
                b_reg   <= b_reg >> 1;
                cnt_reg <= cnt_reg + 4'd1;
                if (cnt_reg == 4'd15) begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    assign done = done_reg;
    assign p    = acc_reg;

endmodule
